// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the angle unit.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a consequent holds in the same cycle as its antecedent
`define SABV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define SABV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sabv_pkg.sv =====
// Shared widths, types and the arctangent table of the signed angle unit.
// No dependencies.
`default_nettype none

package sabv_pkg;

    localparam int CW       = 16;   // input component width
    localparam int PW       = 2 * CW;   // product of two components
    localparam int SW       = PW + 2;   // dot product and cross components
    localparam int RW       = CW + SW;  // axis times cross component
    localparam int TW       = RW + 2;   // triple product
    localparam int DW       = SW + 2;   // CORDIC x and y datapath
    localparam int ZW       = 26;       // angle accumulator, 2^-24 turn
    localparam int STEPS    = 16;       // CORDIC iterations per pass
    localparam int STEP_W   = 5;
    localparam int GAIN_W   = 19;
    localparam int MW       = DW + GAIN_W;  // gain correction product
    localparam int GAIN_SH  = 20;

    localparam logic [GAIN_W-1:0] INV_GAIN_SQ = GAIN_W'(386669);
    localparam logic [MW-1:0]     GAIN_ROUND  = MW'(1) << (GAIN_SH - 1);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(4194304);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(8388608);
    localparam logic [15:0] ANGLE_PI   = 16'd32768;
    localparam logic [15:0] ANGLE_ZERO = 16'd0;

    localparam logic [ZW-1:0] ATAN_TABLE [32] = '{
        ZW'(2097152), ZW'(1238021), ZW'(654136), ZW'(332050),
        ZW'(166669),  ZW'(83416),   ZW'(41718),  ZW'(20860),
        ZW'(10430),   ZW'(5215),    ZW'(2608),   ZW'(1304),
        ZW'(652),     ZW'(326),     ZW'(163),    ZW'(81),
        ZW'(41),      ZW'(20),      ZW'(10),     ZW'(5),
        ZW'(3),       ZW'(1),       ZW'(1),      ZW'(0),
        ZW'(0),       ZW'(0),       ZW'(0),      ZW'(0),
        ZW'(0),       ZW'(0),       ZW'(0),      ZW'(0)
    };

    // Values that ride along the rotation chain
    typedef struct packed {
        logic signed [SW-1:0] dot;
        logic signed [SW-1:0] cz;
        logic                 zero;
        logic                 neg;
    } side_t;

    // Contents of one rotation cell
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
        side_t                side;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [STEP_W-1:0] idx);
        atan_q24 = ATAN_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sabv_front.sv =====
// Front end: products, dot and cross products, sign of the triple product.
// Depends on sabv_pkg.
`default_nettype none

module sabv_front
    import sabv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [CW-1:0] first_x,
    input  wire logic signed [CW-1:0] first_y,
    input  wire logic signed [CW-1:0] first_z,
    input  wire logic signed [CW-1:0] second_x,
    input  wire logic signed [CW-1:0] second_y,
    input  wire logic signed [CW-1:0] second_z,
    input  wire logic signed [CW-1:0] axis_x,
    input  wire logic signed [CW-1:0] axis_y,
    input  wire logic signed [CW-1:0] axis_z,
    output logic                      out_valid,
    output cord_t                     out_data
);

    logic [3:0]           valid_reg;
    logic signed [PW-1:0] prod_reg [9];
    logic signed [CW-1:0] ax1_reg, ay1_reg, az1_reg, ax2_reg, ay2_reg, az2_reg;
    logic signed [SW-1:0] dot2_reg, cx2_reg, cy2_reg, cz2_reg;
    logic signed [SW-1:0] dot3_reg, cx3_reg, cy3_reg, cz3_reg;
    logic signed [RW-1:0] term_reg [3];
    cord_t                data_reg;

    logic signed [TW-1:0] triple;
    logic                 zero;
    logic signed [DW-1:0] cx_wide, cy_wide;
    cord_t                data_next;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // Stage one: the nine component products
    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg[0] <= first_x * second_x;
            prod_reg[1] <= first_y * second_y;
            prod_reg[2] <= first_z * second_z;
            prod_reg[3] <= first_y * second_z;
            prod_reg[4] <= first_z * second_y;
            prod_reg[5] <= first_z * second_x;
            prod_reg[6] <= first_x * second_z;
            prod_reg[7] <= first_x * second_y;
            prod_reg[8] <= first_y * second_x;
            ax1_reg     <= axis_x;
            ay1_reg     <= axis_y;
            az1_reg     <= axis_z;
        end
    end

    // Stage two: dot product and cross product
    always_ff @(posedge clk) begin
        if (en) begin
            dot2_reg <= SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
            cx2_reg  <= SW'(prod_reg[3]) - SW'(prod_reg[4]);
            cy2_reg  <= SW'(prod_reg[5]) - SW'(prod_reg[6]);
            cz2_reg  <= SW'(prod_reg[7]) - SW'(prod_reg[8]);
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            az2_reg  <= az1_reg;
        end
    end

    // Stage three: axis times cross product terms
    always_ff @(posedge clk) begin
        if (en) begin
            term_reg[0] <= RW'(ax2_reg) * RW'(cx2_reg);
            term_reg[1] <= RW'(ay2_reg) * RW'(cy2_reg);
            term_reg[2] <= RW'(az2_reg) * RW'(cz2_reg);
            dot3_reg    <= dot2_reg;
            cx3_reg     <= cx2_reg;
            cy3_reg     <= cy2_reg;
            cz3_reg     <= cz2_reg;
        end
    end

    // Stage four: triple sign, zero test, magnitudes for the first rotation
    assign triple  = TW'(term_reg[0]) + TW'(term_reg[1]) + TW'(term_reg[2]);
    assign zero    = (cx3_reg == '0) && (cy3_reg == '0) && (cz3_reg == '0);
    assign cx_wide = DW'(cx3_reg);
    assign cy_wide = DW'(cy3_reg);

    always_comb begin
        data_next.x         = cx_wide[DW-1] ? -cx_wide : cx_wide;
        data_next.y         = cy_wide[DW-1] ? -cy_wide : cy_wide;
        data_next.z         = '0;
        data_next.side.dot  = dot3_reg;
        data_next.side.cz   = cz3_reg;
        data_next.side.zero = zero;
        data_next.side.neg  = triple[TW-1];
    end

    always_ff @(posedge clk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/sabv_cell.sv =====
// One CORDIC vectoring cell: a single rotation step, then a register.
// Depends on sabv_pkg.
`default_nettype none

module sabv_cell
    import sabv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [STEP_W-1:0] step,
    input  wire logic              in_valid,
    input  wire cord_t             in_data,
    output logic                   out_valid,
    output cord_t                  out_data
);

    logic signed [DW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in, dz;
    cord_t                data_next;
    logic                 valid_reg;
    cord_t                data_reg;

    assign x_in = in_data.x;
    assign y_in = in_data.y;
    assign z_in = in_data.z;
    assign dx   = y_in >>> step;
    assign dy   = x_in >>> step;
    assign dz   = atan_q24(step);

    // Rotate towards the x axis
    always_comb begin
        data_next = in_data;
        if (y_in > 0) begin
            data_next.x = x_in + dx;
            data_next.y = y_in - dy;
            data_next.z = z_in + dz;
        end
        else begin
            data_next.x = x_in - dx;
            data_next.y = y_in + dy;
            data_next.z = z_in - dz;
        end
    end

    // Hold the valid bit
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/signed_angle_between_vectors_unit.sv =====
// Signed angle between two 3D vectors about a reference axis, as a binary angle.
// Stages: 4 front stages, two 16-cell magnitude chains, 2 gain stages, a 16-cell
// arctangent chain and the output register. Throughput one item a cycle, set by the
// chain of CORDIC cells, while the output buffer is not full; a two-entry output buffer
// keeps input open while a result waits. Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module signed_angle_between_vectors_unit
    import sabv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [CW-1:0] first_x,
    input  wire logic signed [CW-1:0] first_y,
    input  wire logic signed [CW-1:0] first_z,
    input  wire logic signed [CW-1:0] second_x,
    input  wire logic signed [CW-1:0] second_y,
    input  wire logic signed [CW-1:0] second_z,
    input  wire logic signed [CW-1:0] axis_x,
    input  wire logic signed [CW-1:0] axis_y,
    input  wire logic signed [CW-1:0] axis_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [15:0]               angle
);

    logic  en;
    logic  m1_valid [STEPS+1];
    cord_t m1_data  [STEPS+1];
    logic  m2_valid [STEPS+1];
    cord_t m2_data  [STEPS+1];
    logic  a_valid  [STEPS+1];
    cord_t a_data   [STEPS+1];

    logic signed [DW-1:0] cz_wide;
    logic                 g1_valid_reg, g2_valid_reg;
    logic [MW-1:0]        gprod_reg;
    side_t                g1_side_reg;
    cord_t                g2_data_reg;
    cord_t                g2_next;
    logic [MW-1:0]        rounded;
    logic signed [DW-1:0] scaled, dot_wide;

    cord_t                fin;
    logic signed [ZW-1:0] z_clamp;
    logic [ZW-1:0]        z_round;
    logic [15:0]          result;

    logic                 out_valid_reg, skid_valid_reg;
    logic [15:0]          out_reg, skid_reg;
    logic                 push, pop;

    // Stall everything only when the output buffer is full
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    sabv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .first_x   (first_x),
        .first_y   (first_y),
        .first_z   (first_z),
        .second_x  (second_x),
        .second_y  (second_y),
        .second_z  (second_z),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .axis_z    (axis_z),
        .out_valid (m1_valid[0]),
        .out_data  (m1_data[0])
    );

    // Feed the second magnitude pass with |cz|
    assign cz_wide = DW'(m1_data[STEPS].side.cz);
    always_comb begin
        m2_data[0]   = m1_data[STEPS];
        m2_data[0].y = cz_wide[DW-1] ? -cz_wide : cz_wide;
        m2_data[0].z = '0;
    end
    assign m2_valid[0] = m1_valid[STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_chain
        sabv_cell u_mag1 (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (STEP_W'(g)),
            .in_valid  (m1_valid[g]),
            .in_data   (m1_data[g]),
            .out_valid (m1_valid[g+1]),
            .out_data  (m1_data[g+1])
        );
        sabv_cell u_mag2 (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (STEP_W'(g)),
            .in_valid  (m2_valid[g]),
            .in_data   (m2_data[g]),
            .out_valid (m2_valid[g+1]),
            .out_data  (m2_data[g+1])
        );
        sabv_cell u_atan (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (STEP_W'(g)),
            .in_valid  (a_valid[g]),
            .in_data   (a_data[g]),
            .out_valid (a_valid[g+1]),
            .out_data  (a_data[g+1])
        );
    end

    // Gain stage one: multiply the length by the inverse squared gain
    always_ff @(posedge clk) begin
        if (en) begin
            gprod_reg   <= MW'(unsigned'(m2_data[STEPS].x)) * MW'(INV_GAIN_SQ);
            g1_side_reg <= m2_data[STEPS].side;
        end
    end

    // Gain stage two: round, then fold a negative dot into the first quadrant
    assign rounded  = (gprod_reg + GAIN_ROUND) >> GAIN_SH;
    assign scaled   = DW'(rounded);
    assign dot_wide = DW'(g1_side_reg.dot);

    always_comb begin
        g2_next.side = g1_side_reg;
        if (dot_wide[DW-1]) begin
            g2_next.x = scaled;
            g2_next.y = -dot_wide;
            g2_next.z = QUARTER_TURN;
        end
        else begin
            g2_next.x = dot_wide;
            g2_next.y = scaled;
            g2_next.z = '0;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            g2_data_reg <= g2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
        end
        else if (en) begin
            g1_valid_reg <= m2_valid[STEPS];
            g2_valid_reg <= g1_valid_reg;
        end
    end

    assign a_valid[0] = g2_valid_reg;
    assign a_data[0]  = g2_data_reg;

    // Clamp, round to 16 bits, apply the special cases and the sign
    assign fin     = a_data[STEPS];
    assign z_clamp = (fin.z < 0) ? '0 : ((fin.z > HALF_TURN) ? HALF_TURN : fin.z);
    assign z_round = (unsigned'(z_clamp) + ZW'(128)) >> 8;

    always_comb begin
        if (fin.side.zero) begin
            result = fin.side.dot[SW-1] ? ANGLE_PI : ANGLE_ZERO;
        end
        else begin
            result = z_round[15:0];
        end
        if (fin.side.neg) begin
            result = ANGLE_ZERO - result;
        end
    end

    // Output register with a skid entry behind it
    assign push = en && a_valid[STEPS];
    assign pop  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !pop) begin
            if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= push;
        end
    end

    always_ff @(posedge clk) begin
        if (out_valid_reg && !pop) begin
            if (push) begin
                skid_reg <= result;
            end
        end
        else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end
        else if (push) begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign angle     = out_reg;

endmodule

`default_nettype wire

// ===== rtl/sabv_checker.sv =====
// Port-level checks on the signed angle unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sabv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] angle
);

    // Hold a stalled result
    `SABV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(angle), "result dropped or changed while stalled")

    // Close the input only behind a waiting result
    `SABV_ASSERT_NOW(a_ready_low, !in_ready, out_valid, "input closed with no result waiting")

    // Close the input only after a stalled result
    `SABV_ASSERT_NOW(a_ready_fall, $fell(in_ready), $past(out_valid && !out_ready), "input closed without output stall")

    // Reopen the input only when the waiting result moves on
    `SABV_ASSERT_NOW(a_ready_rise, $rose(in_ready) && in_valid, $past(out_ready), "input reopened without a transfer")

endmodule

bind signed_angle_between_vectors_unit sabv_checker u_sabv_checker (.*);

`default_nettype wire
